@@ hdl/rss_pkg.sv @@
package rss_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 17;

  // Fixed field widths of the command and result words
  localparam int POS_W    = 10;
  localparam int RANK_W   = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  // Operation codes on the cmd port
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SEARCH_CMP,
    S_DUP_CHK,
    S_UP_RD,
    S_UP_WR,
    S_RM_RD,
    S_RM_WR
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;         // latch the input word, open the search window
    logic    search_rd;    // read the midpoint of the window
    logic    search_upd;   // narrow the window from the read key
    logic    dup_rd;       // read the entry at the insert point
    logic    ptr_init_up;  // pointer to the top of the stored keys
    logic    ptr_init_rm;  // pointer to the removed position
    logic    up_rd;        // read entry below the pointer
    logic    up_wr;        // move it up one place, step pointer down
    logic    ins_wr;       // write new key at the insert point
    logic    rm_rd;        // read entry above the pointer
    logic    rm_wr;        // move it down one place, step pointer up
    logic    rm_dec;       // drop one from the count
    logic    finish;       // register the result word
    status_t status;       // status of the result word
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_remove;
    logic lo_lt_hi;
    logic lo_lt_count;
    logic dup_match;
    logic full;
    logic pos_bad;
    logic ptr_gt_lo;
    logic ptr1_lt_count;
  } stat_t;

endpackage

@@ hdl/rss_ctrl.sv @@
module rss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rss_pkg::stat_t stat,
  output rss_pkg::ctl_t  ctl
);
  import rss_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.status = ST_INSERTED;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_remove) begin
          if (stat.pos_bad) begin
            ctl.finish = 1'b1;
            ctl.status = ST_BADPOS;
            state_next = S_IDLE;
          end else begin
            ctl.ptr_init_rm = 1'b1;
            state_next      = S_RM_RD;
          end
        end else begin
          state_next = S_SEARCH;
        end
      end
      // Binary search for the first entry not greater than the key
      S_SEARCH: begin
        if (stat.lo_lt_hi) begin
          ctl.search_rd = 1'b1;
          state_next    = S_SEARCH_CMP;
        end else if (stat.lo_lt_count) begin
          ctl.dup_rd = 1'b1;
          state_next = S_DUP_CHK;
        end else if (stat.full) begin
          ctl.finish = 1'b1;
          ctl.status = ST_FULL;
          state_next = S_IDLE;
        end else begin
          ctl.ptr_init_up = 1'b1;
          state_next      = S_UP_RD;
        end
      end
      S_SEARCH_CMP: begin
        ctl.search_upd = 1'b1;
        state_next     = S_SEARCH;
      end
      S_DUP_CHK: begin
        if (stat.dup_match) begin
          ctl.finish = 1'b1;
          ctl.status = ST_DUP;
          state_next = S_IDLE;
        end else if (stat.full) begin
          ctl.finish = 1'b1;
          ctl.status = ST_FULL;
          state_next = S_IDLE;
        end else begin
          ctl.ptr_init_up = 1'b1;
          state_next      = S_UP_RD;
        end
      end
      // Open a slot: move entries up from the top down to the insert point
      S_UP_RD: begin
        if (stat.ptr_gt_lo) begin
          ctl.up_rd  = 1'b1;
          state_next = S_UP_WR;
        end else begin
          ctl.ins_wr = 1'b1;
          ctl.finish = 1'b1;
          ctl.status = ST_INSERTED;
          state_next = S_IDLE;
        end
      end
      S_UP_WR: begin
        ctl.up_wr  = 1'b1;
        state_next = S_UP_RD;
      end
      // Close the gap: move entries down from the removed position
      S_RM_RD: begin
        if (stat.ptr1_lt_count) begin
          ctl.rm_rd  = 1'b1;
          state_next = S_RM_WR;
        end else begin
          ctl.rm_dec = 1'b1;
          ctl.finish = 1'b1;
          ctl.status = ST_REMOVED;
          state_next = S_IDLE;
        end
      end
      S_RM_WR: begin
        ctl.rm_wr  = 1'b1;
        state_next = S_RM_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/rss_dpath.sv @@
module rss_dpath #(
  parameter int CAPACITY = rss_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = rss_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rss_pkg::ctl_t                 ctl,
  output rss_pkg::stat_t                stat,
  input  logic                          cmd,
  input  logic [KEY_BITS-1:0]           key,
  input  logic [rss_pkg::POS_W-1:0]     position,
  output logic                          done,
  output logic [rss_pkg::RANK_W-1:0]    rank,
  output logic [rss_pkg::STATUS_W-1:0]  status,
  output logic [rss_pkg::COUNT_W-1:0]   stored_count
);
  import rss_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Key store, descending order, entries below count valid
  logic [KEY_BITS-1:0] ordered_keys [CAPACITY];
  logic [KEY_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic                wr_en;

  // Working registers
  logic                cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [POS_W-1:0]    pos_r;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hi;
  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_after;
  logic [CNT_W:0]      mid_sum;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    ptr_m1;
  logic [CNT_W-1:0]    ptr_p1;
  status_t             status_r;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign ptr_m1  = ptr - CNT_W'(1);
  assign ptr_p1  = ptr + CNT_W'(1);

  // Status back to the controller
  always_comb begin
    stat.is_remove     = (cmd_r == CMD_REMOVE);
    stat.lo_lt_hi      = (lo < hi);
    stat.lo_lt_count   = (lo < count);
    stat.dup_match     = (rd_data == key_r);
    stat.full          = (count == CNT_W'(CAPACITY));
    stat.pos_bad       = (CMP_W'(pos_r) >= CMP_W'(count));
    stat.ptr_gt_lo     = (ptr > lo);
    stat.ptr1_lt_count = (ptr_p1 < count);
  end

  // Memory port selection
  always_comb begin
    rd_en   = ctl.search_rd | ctl.dup_rd | ctl.up_rd | ctl.rm_rd;
    rd_addr = lo[ADDR_W-1:0];
    if (ctl.search_rd) begin
      rd_addr = mid[ADDR_W-1:0];
    end else if (ctl.up_rd) begin
      rd_addr = ptr_m1[ADDR_W-1:0];
    end else if (ctl.rm_rd) begin
      rd_addr = ptr_p1[ADDR_W-1:0];
    end
    wr_en   = ctl.up_wr | ctl.rm_wr | ctl.ins_wr;
    wr_addr = ctl.ins_wr ? lo[ADDR_W-1:0] : ptr[ADDR_W-1:0];
    wr_data = ctl.ins_wr ? key_r : rd_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ordered_keys[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ordered_keys[wr_addr] <= wr_data;
    end
  end

  // Input word, search window and move pointer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd;
      key_r <= key;
      pos_r <= position;
      lo    <= '0;
      hi    <= count;
    end
    if (ctl.search_upd) begin
      if (rd_data > key_r) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (ctl.ptr_init_up) begin
      ptr <= count;
    end else if (ctl.ptr_init_rm) begin
      ptr <= CNT_W'(pos_r);
    end else if (ctl.up_wr) begin
      ptr <= ptr_m1;
    end else if (ctl.rm_wr) begin
      ptr <= ptr_p1;
    end
  end

  // Stored key count
  always_comb begin
    count_after = count;
    if (ctl.ins_wr) begin
      count_after = count + CNT_W'(1);
    end else if (ctl.rm_dec) begin
      count_after = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_after;
    end
  end

  // Result word, shown for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      rank         <= (ctl.status == ST_INSERTED) ? RANK_W'(lo) : '0;
      status_r     <= ctl.status;
      stored_count <= COUNT_W'(count_after);
    end
  end

  assign status = status_r;

endmodule

@@ hdl/ranked_sorted_set.sv @@
// Ranked sorted set: up to CAPACITY distinct keys kept largest first.
// Command channel: start with cmd, key, position is taken when busy is low.
//   cmd insert stores key and reports its rank (count of larger keys);
//   cmd remove deletes the key at position, counting from the largest.
// Result channel: done is high for exactly one cycle with rank, status and
//   stored_count; the receiver cannot stall, so results are never held.
// Status: inserted, removed, full, bad position or duplicate key; the rank
//   field is zero for anything but a successful insert.
// Sequencing, with n keys held: the keys sit in one memory with one read
//   port, and each search probe or entry move is a read and then a compare
//   or write. Insert searches, moves the n - rank smaller keys up one place
//   and writes the key; a duplicate or full insert ends after the search.
//   Remove moves the n - 1 - position keys after it down; a bad position
//   moves none. One word is in flight at a time; busy drops in the cycle
//   that done is shown, so the next word can be taken at the edge that ends it.
// Reset: rst (synchronous) empties the set at once; stored keys are not
//   cleared, since only entries below the count are ever read.
module ranked_sorted_set #(
  parameter int CAPACITY = rss_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = rss_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [KEY_BITS-1:0]           key,
  input  logic [rss_pkg::POS_W-1:0]     position,
  output logic                          done,
  output logic [rss_pkg::RANK_W-1:0]    rank,
  output logic [rss_pkg::STATUS_W-1:0]  status,
  output logic [rss_pkg::COUNT_W-1:0]   stored_count
);
  import rss_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // Sequencer
  rss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Key store and arithmetic
  rss_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cmd          (cmd),
    .key          (key),
    .position     (position),
    .done         (done),
    .rank         (rank),
    .status       (status),
    .stored_count (stored_count)
  );

endmodule
